// ===== hw/rtl/i2cbm_pkg.sv =====
// Shared types and constants of the I2C byte master.
package i2cbm_pkg;

  localparam int unsigned PhaseW   = 16;
  localparam int unsigned PollW    = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ActionW  = 3;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  localparam logic [PhaseW-1:0] PhaseTicksRst   = 16'd20;
  localparam logic [PollW-1:0]  AckPollLimitRst = 8'd100;

  // Command codes.
  localparam logic [ActionW-1:0] ActNone     = 3'd0;
  localparam logic [ActionW-1:0] ActStart    = 3'd1;
  localparam logic [ActionW-1:0] ActStop     = 3'd2;
  localparam logic [ActionW-1:0] ActWrite    = 3'd3;
  localparam logic [ActionW-1:0] ActReadAck  = 3'd4;
  localparam logic [ActionW-1:0] ActReadNack = 3'd5;

  // Configuration register indexes.
  localparam logic CfgPhaseTicks   = 1'b0;
  localparam logic CfgAckPollLimit = 1'b1;

  // Sequencer steps, one-hot.
  typedef enum logic [24:0] {
    S_IDLE     = 25'd1 << 0,
    S_ST_A     = 25'd1 << 1,
    S_ST_B     = 25'd1 << 2,
    S_ST_C     = 25'd1 << 3,
    S_SP_A     = 25'd1 << 4,
    S_SP_B     = 25'd1 << 5,
    S_WR_SET   = 25'd1 << 6,
    S_WR_HIGH  = 25'd1 << 7,
    S_WR_LOW   = 25'd1 << 8,
    S_WR_PAD   = 25'd1 << 9,
    S_AK_REL   = 25'd1 << 10,
    S_AK_HIGH  = 25'd1 << 11,
    S_AK_POLL  = 25'd1 << 12,
    S_AK_LOW   = 25'd1 << 13,
    S_RD_PRE   = 25'd1 << 14,
    S_RD_HIGH  = 25'd1 << 15,
    S_RD_LOW   = 25'd1 << 16,
    S_RD_TAIL  = 25'd1 << 17,
    S_AA_DRIVE = 25'd1 << 18,
    S_AA_LOW   = 25'd1 << 19,
    S_AA_HIGH  = 25'd1 << 20,
    S_AA_END   = 25'd1 << 21,
    S_AA_REL   = 25'd1 << 22,
    S_NA_REL   = 25'd1 << 23,
    S_SPARE    = 25'd1 << 24
  } step_e;

  typedef struct packed {
    logic scl;
    logic sda_low;
  } lines_t;

  // Line levels after entering a step.
  function automatic lines_t enter_lines(step_e st, logic msb, lines_t cur);
    lines_t l;
    l = cur;
    case (st)
      S_ST_A:     begin l.sda_low = 1'b0; l.scl = 1'b1; end
      S_ST_B:     l.sda_low = 1'b1;
      S_ST_C:     l.scl = 1'b0;
      S_SP_A:     begin l.sda_low = 1'b1; l.scl = 1'b1; end
      S_SP_B:     l.sda_low = 1'b0;
      S_WR_SET:   l.sda_low = ~msb;
      S_WR_HIGH:  l.scl = 1'b1;
      S_WR_LOW:   l.scl = 1'b0;
      S_AK_REL:   l.sda_low = 1'b0;
      S_AK_HIGH:  l.scl = 1'b1;
      S_AK_LOW:   l.scl = 1'b0;
      S_RD_PRE:   begin l.sda_low = 1'b0; l.scl = 1'b0; end
      S_RD_HIGH:  l.scl = 1'b1;
      S_RD_LOW:   l.scl = 1'b0;
      S_AA_DRIVE: l.sda_low = 1'b1;
      S_AA_LOW:   l.scl = 1'b0;
      S_AA_HIGH:  l.scl = 1'b1;
      S_AA_END:   l.scl = 1'b0;
      S_AA_REL:   l.sda_low = 1'b0;
      S_NA_REL:   l.sda_low = 1'b0;
      default:    l = cur;
    endcase
    return l;
  endfunction

endpackage

// ===== hw/rtl/i2c_byte_master.sv =====
// Top level of the I2C byte master sequencer.
//
// Each request on the input stream is one tick of the I2C line sequencer and
// produces exactly one result request carrying the SCL level, the SDA pull-down,
// busy, a done pulse, the last received byte and the acknowledge flag. While idle,
// the action field starts a command: start, stop, write byte (ack checked), read
// byte then ACK or read byte then NACK; actions arriving while busy or outside
// 1..5 are ignored. Every line phase lasts phase_ticks requests (0 counts as 1);
// the write acknowledge window samples sda_in once per request, up to
// ack_poll_limit samples (0 counts as 1). Rate: one request per clock cycle;
// the next sequencer state and the result are computed combinationally from
// the state registers and the incoming request, then held in a one-entry result
// register. The input is ready whenever that register is empty or is being
// drained in the same cycle, so an output stall backs up to the input at once.
// Configuration writes are taken at any time (cfg_ready_o is always high) and
// are meant to happen while no command is running.
module i2c_byte_master
  import i2cbm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [2:0] action, [10:3] tx_byte, [11] sda_in, [15:12] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] scl_level, [1] sda_pull_low, [2] busy_res, [3] done_res,
  // [11:4] rx_byte, [12] ack_seen, [15:13] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [PhaseW-1:0]   cfg_data_i
);

  // Configuration.
  logic [PhaseW-1:0] phase_ticks_q;
  logic [PollW-1:0]  poll_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PhaseTicksRst;
      poll_limit_q  <= AckPollLimitRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgPhaseTicks:   phase_ticks_q <= cfg_data_i;
        CfgAckPollLimit: poll_limit_q  <= cfg_data_i[PollW-1:0];
        default:         phase_ticks_q <= phase_ticks_q;
      endcase
    end
  end

  // Request fields.
  logic [ActionW-1:0] action;
  logic [ByteW-1:0]   tx_byte;
  logic               sda_in;

  assign action  = s_axis_tdata[2:0];
  assign tx_byte = s_axis_tdata[10:3];
  assign sda_in  = s_axis_tdata[11];

  // Sequencer state.
  step_e              step_q, step_d;
  logic [3:0]         bit_q, bit_d;
  logic [ByteW-1:0]   shift_q, shift_d;
  logic [PhaseW-1:0]  pc_q, pc_d;
  logic [PollW-1:0]   poll_q, poll_d;
  logic [ActionW-1:0] kind_q, kind_d;
  lines_t             lines_q, lines_d;
  logic [ByteW-1:0]   rx_q, rx_d;
  logic               ack_q, ack_d;

  logic               acc;
  logic               out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  // Next-state scratch.
  lines_t             now_lines;
  logic               busy, done, go;
  step_e              nxt;
  logic [PhaseW-1:0]  hold;
  logic [PollW-1:0]   lim;

  assign hold = (phase_ticks_q == '0) ? PhaseW'(1) : phase_ticks_q;
  assign lim  = (poll_limit_q == '0) ? PollW'(1) : poll_limit_q;

  always_comb begin
    step_d  = step_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    pc_d    = pc_q;
    poll_d  = poll_q;
    kind_d  = kind_q;
    lines_d = lines_q;
    rx_d    = rx_q;
    ack_d   = ack_q;
    busy    = 1'b0;
    done    = 1'b0;
    go      = 1'b0;
    nxt     = S_IDLE;

    // Command launch: first phase begins on this tick.
    if (step_q == S_IDLE && action >= ActStart && action <= ActReadNack) begin
      kind_d = action;
      bit_d  = '0;
      pc_d   = '0;
      case (action)
        ActStart: step_d = S_ST_A;
        ActStop:  step_d = S_SP_A;
        ActWrite: begin
          shift_d = tx_byte;
          step_d  = S_WR_SET;
        end
        default:  step_d = S_RD_PRE;
      endcase
      lines_d = enter_lines(step_d, shift_d[ByteW-1], lines_d);
    end

    now_lines = lines_d;

    if (step_d != S_IDLE) begin
      busy = 1'b1;
      if (step_d == S_AK_POLL) begin
        poll_d = poll_d + PollW'(1);
        if (!sda_in) begin
          ack_d = 1'b1;
          go    = 1'b1;
          nxt   = S_AK_LOW;
        end else if (poll_d >= lim) begin
          ack_d = 1'b0;
          go    = 1'b1;
          nxt   = S_AK_LOW;
        end
      end else if (!(({1'b0, pc_d} + (PhaseW + 1)'(1)) >= {1'b0, hold})) begin
        pc_d = pc_d + PhaseW'(1);
      end else begin
        go = 1'b1;
        case (step_d)
          S_ST_A:     nxt = S_ST_B;
          S_ST_B:     nxt = S_ST_C;
          S_SP_A:     nxt = S_SP_B;
          S_WR_SET:   nxt = S_WR_HIGH;
          S_WR_HIGH:  nxt = S_WR_LOW;
          S_WR_LOW: begin
            shift_d = {shift_d[ByteW-2:0], 1'b0};
            bit_d   = bit_d + 4'd1;
            nxt     = (bit_d >= 4'd8) ? S_WR_PAD : S_WR_SET;
          end
          S_WR_PAD: begin
            bit_d = bit_d + 4'd1;
            if (bit_d >= 4'd4) begin
              nxt = S_AK_REL;
            end else begin
              go   = 1'b0;
              pc_d = '0;
            end
          end
          S_AK_REL:   nxt = S_AK_HIGH;
          S_AK_HIGH:  nxt = S_AK_POLL;
          S_RD_PRE: begin
            shift_d = '0;
            nxt     = S_RD_HIGH;
          end
          S_RD_HIGH: begin
            shift_d = {shift_d[ByteW-2:0], sda_in};
            rx_d    = shift_d;
            nxt     = S_RD_LOW;
          end
          S_RD_LOW: begin
            bit_d = bit_d + 4'd1;
            nxt   = (bit_d >= 4'd8) ? S_RD_TAIL : S_RD_HIGH;
          end
          S_RD_TAIL:  nxt = (kind_d == ActReadAck) ? S_AA_DRIVE : S_NA_REL;
          S_AA_DRIVE: nxt = S_AA_LOW;
          S_NA_REL:   nxt = S_AA_LOW;
          S_AA_LOW:   nxt = S_AA_HIGH;
          S_AA_HIGH:  nxt = S_AA_END;
          S_AA_END: begin
            if (kind_d == ActReadAck) begin
              nxt = S_AA_REL;
            end else begin
              nxt  = S_IDLE;
              done = 1'b1;
            end
          end
          default: begin
            // final steps of start, stop, write ack and read ack
            nxt  = S_IDLE;
            done = 1'b1;
          end
        endcase
      end

      if (go) begin
        step_d  = nxt;
        pc_d    = '0;
        lines_d = enter_lines(nxt, shift_d[ByteW-1], lines_d);
        if (nxt == S_WR_PAD) begin
          bit_d = '0;
        end
        if (nxt == S_AK_POLL) begin
          poll_d = '0;
        end
      end
    end
  end

  // Result register: input stays open while the result drains this cycle.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_IDLE;
      bit_q       <= '0;
      shift_q     <= '0;
      pc_q        <= '0;
      poll_q      <= '0;
      kind_q      <= ActNone;
      lines_q     <= '{scl: 1'b1, sda_low: 1'b0};
      rx_q        <= '0;
      ack_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        step_q  <= step_d;
        bit_q   <= bit_d;
        shift_q <= shift_d;
        pc_q    <= pc_d;
        poll_q  <= poll_d;
        kind_q  <= kind_d;
        lines_q <= lines_d;
        rx_q    <= rx_d;
        ack_q   <= ack_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_data_q <= {3'b000, ack_d, rx_d, done, busy, now_lines.sda_low, now_lines.scl};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== hw/rtl/i2cbm_checker.sv =====
// Port-level checker for the I2C byte master, bound to the top level.
module i2cbm_checker
  import i2cbm_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                cfg_ready_o
);

  // done only on a busy tick
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tdata[3] || m_axis_tdata[2]))
    else $error("done without busy");

  // a stalled result blocks the input side
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input ready while result stalled");

  // empty result register always takes a request
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input not ready while result register empty");

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind i2c_byte_master i2cbm_checker u_i2cbm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready_o   (cfg_ready_o)
);
